@@ hw/rtl/ycn_pkg.sv @@
package ycn_pkg;

    // Image geometry limits and field widths.
    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 4096;
    localparam int MinSize   = 3;
    localparam int AddrW     = $clog2(MaxWidth);
    localparam int ColW      = 10;
    localparam int RowW      = 12;
    localparam int WidthW    = 11;
    localparam int HeightW   = 13;
    localparam int CfgDataW  = 13;
    localparam int ValueW    = 3;

    localparam logic [WidthW-1:0]  WidthReset  = WidthW'(66);
    localparam logic [HeightW-1:0] HeightReset = HeightW'(66);

    // Register indexes of the configuration port.
    typedef enum logic [0:0] {
        CfgImageWidth  = 1'b0,
        CfgImageHeight = 1'b1
    } t_cfg_reg;

    // Corner neighborhood classes.
    typedef enum logic [1:0] {
        ClsS = 2'd0,
        ClsQ = 2'd1,
        ClsR = 2'd2
    } t_corner_cls;

    // Value given when all four corners are of class r.
    localparam logic [ValueW-1:0] AllRValue = ValueW'(5);

    // Classify one corner neighborhood by the h rule.
    function automatic t_corner_cls corner_class(input logic b, input logic c,
                                                 input logic d, input logic e);
        t_corner_cls cls;
        if (b != c) begin
            cls = ClsS;
        end else if (b == d && b == e) begin
            cls = ClsR;
        end else begin
            cls = ClsQ;
        end
        return cls;
    endfunction

    // Yokoi 4-connectivity number of a foreground center from its 3x3 window.
    // Bit order of nbr: x1 right, x2 up, x3 left, x4 down, x5 up-right,
    // x6 up-left, x7 down-left, x8 down-right at nbr[0] .. nbr[7].
    function automatic logic [ValueW-1:0] yokoi_number(input logic x0,
                                                      input logic [7:0] nbr);
        t_corner_cls        k0, k1, k2, k3;
        logic [ValueW-1:0]  q;
        k0 = corner_class(x0, nbr[0], nbr[4], nbr[1]);
        k1 = corner_class(x0, nbr[1], nbr[5], nbr[2]);
        k2 = corner_class(x0, nbr[2], nbr[6], nbr[3]);
        k3 = corner_class(x0, nbr[3], nbr[7], nbr[0]);
        q = ValueW'(k0 == ClsQ) + ValueW'(k1 == ClsQ)
          + ValueW'(k2 == ClsQ) + ValueW'(k3 == ClsQ);
        if (!x0) begin
            return '0;
        end else if (k0 == ClsR && k1 == ClsR && k2 == ClsR && k3 == ClsR) begin
            return AllRValue;
        end else begin
            return q;
        end
    endfunction

endpackage

@@ hw/rtl/yokoi_connectivity_number.sv @@
// Yokoi 4-connectivity number over a streamed, zero-padded binary image in raster
// order. One pixel request is accepted per clock unless o_in_stall is high; the
// result for the interior pixel above-left of the current pixel passes the second
// stage and the output register, and with no output stall the sustained rate is
// one pixel per cycle. The two previous rows live in one 1024 x 2-bit synchronous
// memory: each pixel reads its column in the accept cycle and writes the updated
// column back as it leaves the second stage. No result is given for the first or
// last row or column. A write to image_width or image_height restarts the frame
// at row 0, column 0; widths are clamped to 3..1024 and heights to 3..4096.
module yokoi_connectivity_number (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Pixel input channel.
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_pixel,
    // Result output channel.
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ycn_pkg::RowW-1:0]   o_center_row,
    output logic [ycn_pkg::ColW-1:0]   o_center_col,
    output logic                       o_is_foreground,
    output logic [ycn_pkg::ValueW-1:0] o_yokoi_value,
    output logic                       o_last_of_image,
    // Configuration write port.
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_index,
    input  logic [ycn_pkg::CfgDataW-1:0] i_cfg_data
);
    import ycn_pkg::*;

    // Configuration registers.
    logic [WidthW-1:0]  r_width;
    logic [HeightW-1:0] r_height;

    // Raster position of the next incoming pixel.
    logic [ColW-1:0] r_col, n_col;
    logic [RowW-1:0] r_row, n_row;

    // Line memory: bit 0 holds the row two above, bit 1 the row one above.
    logic [1:0]      r_line_mem [MaxWidth];
    logic [1:0]      r_rd_data;

    // Second stage: pixel whose line data is being read back.
    logic            r_b_valid;
    logic            r_b_pixel;
    logic [AddrW-1:0] r_b_addr;
    logic            r_b_emit;
    logic            r_b_last;
    logic [RowW-1:0] r_b_row;
    logic [ColW-1:0] r_b_col;

    // Window of the two previous columns: {left column, center column},
    // each column {bottom, middle, top}.
    logic [5:0]      r_win;

    // Output register.
    logic                r_out_valid;
    logic [RowW-1:0]     r_out_row;
    logic [ColW-1:0]     r_out_col;
    logic                r_out_fg;
    logic [ValueW-1:0]   r_out_value;
    logic                r_out_last;

    logic [WidthW-1:0]  eff_width;
    logic [HeightW-1:0] eff_height;
    logic               in_accept;
    logic               out_free;
    logic               b_move;
    logic               a_emit;
    logic               a_last;
    logic               top, mid;
    logic [ValueW-1:0]  b_value;

    // Clamp the configured geometry to the supported range.
    always_comb begin
        eff_width = r_width;
        if (r_width < WidthW'(MinSize)) begin
            eff_width = WidthW'(MinSize);
        end else if (r_width > WidthW'(MaxWidth)) begin
            eff_width = WidthW'(MaxWidth);
        end
        eff_height = r_height;
        if (r_height < HeightW'(MinSize)) begin
            eff_height = HeightW'(MinSize);
        end else if (r_height > HeightW'(MaxHeight)) begin
            eff_height = HeightW'(MaxHeight);
        end
    end

    // Handshake: the second stage always drains unless its result is blocked.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign b_move     = r_b_valid && (!r_b_emit || out_free);
    assign o_in_stall = r_b_valid && !b_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Interior test and last-pixel test for the incoming position.
    assign a_emit = (r_row >= RowW'(2)) && (r_col >= ColW'(2));
    assign a_last = ({1'b0, r_row} == eff_height - HeightW'(1))
                 && ({1'b0, r_col} == eff_width - WidthW'(1));

    // Next raster position.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if ({1'b0, r_col} + WidthW'(1) >= eff_width) begin
            n_col = '0;
            if ({1'b0, r_row} + HeightW'(1) >= eff_height) begin
                n_row = '0;
            end else begin
                n_row = r_row + RowW'(1);
            end
        end else begin
            n_col = r_col + ColW'(1);
        end
    end

    // Configuration registers and raster position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WidthReset;
            r_height <= HeightReset;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CfgImageWidth:  r_width  <= i_cfg_data[WidthW-1:0];
                CfgImageHeight: r_height <= i_cfg_data;
                default:        r_width  <= r_width;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line memory: read in the accept cycle, write back from the second stage.
    // A read and a write never meet on one column, since a row is at least
    // three pixels long and only one pixel sits in the second stage.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data <= r_line_mem[r_col[AddrW-1:0]];
        end
        if (b_move) begin
            r_line_mem[r_b_addr] <= {r_b_pixel, r_rd_data[1]};
        end
    end

    // Second stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (in_accept) begin
            r_b_valid <= 1'b1;
        end else if (b_move) begin
            r_b_valid <= 1'b0;
        end
    end

    // Second stage payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_b_pixel <= i_pixel;
            r_b_addr  <= r_col[AddrW-1:0];
            r_b_emit  <= a_emit;
            r_b_last  <= a_last;
            r_b_row   <= r_row - RowW'(1);
            r_b_col   <= r_col - ColW'(1);
        end
    end

    // Window shift as each pixel leaves the second stage.
    assign top = r_rd_data[0];
    assign mid = r_rd_data[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_cfg_we) begin
            r_win <= '0;
        end else if (b_move) begin
            r_win <= {r_win[2:0], r_b_pixel, mid, top};
        end
    end

    // Connectivity number of the window center.
    assign b_value = yokoi_number(r_win[1],
        {r_b_pixel, r_win[5], r_win[3], top, r_win[2], r_win[4], r_win[0], mid});

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_move && r_b_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (b_move && r_b_emit) begin
            r_out_row   <= r_b_row;
            r_out_col   <= r_b_col;
            r_out_fg    <= r_win[1];
            r_out_value <= b_value;
            r_out_last  <= r_b_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_center_row    = r_out_row;
    assign o_center_col    = r_out_col;
    assign o_is_foreground = r_out_fg;
    assign o_yokoi_value   = r_out_value;
    assign o_last_of_image = r_out_last;

endmodule
